// ===== design/usb_config_endpoint_extractor_unit_defines.svh =====
// ---------------------------------------------------------------------------
// usb configuration endpoint extractor - assertion macros
// shared property wrappers, sampled on clk and disabled during reset
// ---------------------------------------------------------------------------
`ifndef USB_CONFIG_ENDPOINT_EXTRACTOR_UNIT_DEFINES_SVH
`define USB_CONFIG_ENDPOINT_EXTRACTOR_UNIT_DEFINES_SVH

// same-cycle implication
`define UCEE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define UCEE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ucee_pkg.sv =====
// ---------------------------------------------------------------------------
// ucee_pkg
// types and constants of the usb configuration endpoint extractor
// ---------------------------------------------------------------------------
package ucee_pkg;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // descriptor bytes 2..8 kept for decoding
    localparam int unsigned DESC_BYTES_DEPTH = 7;
    localparam int unsigned DESC_SLOT_W      = $clog2(DESC_BYTES_DEPTH);

    // descriptor types
    localparam logic [7:0] DT_INTERFACE    = 8'h04;
    localparam logic [7:0] DT_ENDPOINT     = 8'h05;
    localparam logic [7:0] DT_SS_COMPANION = 8'h30;

    // length limits
    localparam logic [7:0]  MIN_DESC_LEN      = 8'd2;
    localparam logic [7:0]  IF_DESC_LEN       = 8'd9;
    localparam logic [7:0]  EP_DESC_LEN       = 8'd7;
    localparam logic [7:0]  COMP_DESC_LEN     = 8'd6;
    localparam logic [7:0]  LAST_KEPT_INDEX   = 8'd8;
    localparam logic [15:0] MIN_CONFIG_BYTES  = 16'd9;
    localparam logic [15:0] CONFIG_VALUE_OFFS = 16'd5;
    localparam logic [15:0] OFFSET_MAX        = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] REG_WANTED_CONFIG = 2'd0;
    localparam logic [1:0] REG_TARGET_IF     = 2'd1;
    localparam logic [1:0] REG_TARGET_ALT    = 2'd2;

    localparam logic [7:0] WANTED_CONFIG_RESET = 8'd1;

    typedef enum logic [1:0] {
        WALK_OK        = 2'd0,
        WALK_REJECTED  = 2'd1,
        WALK_MALFORMED = 2'd2
    } walk_status_t;

    typedef struct packed {
        logic [15:0] bytes_per_service;
        logic [1:0]  mult_field;
        logic [7:0]  burst_max;
        logic        has_companion;
        logic [7:0]  poll_interval;
        logic [15:0] max_packet_size;
        logic [1:0]  transfer_type;
        logic [7:0]  endpoint_address;
    } record_t;

    typedef struct packed {
        logic         record_valid;
        record_t      rec;
        walk_status_t status;
        logic         last_result;
    } result_t;

endpackage

// ===== design/ucee_if.sv =====
// ---------------------------------------------------------------------------
// ucee channel interfaces
// byte input, result output and register write channels
// ---------------------------------------------------------------------------
interface ucee_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_blob;

    modport source (output valid, output data_byte, output end_of_blob, input ready);
    modport sink   (input valid, input data_byte, input end_of_blob, output ready);
endinterface

interface ucee_result_if;
    logic        valid;
    logic        ready;
    logic        record_valid;
    logic [7:0]  endpoint_address;
    logic [1:0]  transfer_type;
    logic [15:0] max_packet_size;
    logic [7:0]  poll_interval;
    logic        has_companion;
    logic [7:0]  burst_max;
    logic [1:0]  mult_field;
    logic [15:0] bytes_per_service;
    logic [1:0]  walk_status;
    logic        last_result;

    modport source (
        output valid, output record_valid, output endpoint_address, output transfer_type,
        output max_packet_size, output poll_interval, output has_companion,
        output burst_max, output mult_field, output bytes_per_service,
        output walk_status, output last_result, input ready
    );
    modport sink (
        input valid, input record_valid, input endpoint_address, input transfer_type,
        input max_packet_size, input poll_interval, input has_companion,
        input burst_max, input mult_field, input bytes_per_service,
        input walk_status, input last_result, output ready
    );
endinterface

interface ucee_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] reg_index;
    logic [7:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ===== design/usb_config_endpoint_extractor_unit.sv =====
// ---------------------------------------------------------------------------
// usb_config_endpoint_extractor_unit
// walks a usb configuration descriptor set byte by byte and reports the
// endpoints (with superspeed companions) of one interface/alternate setting
// ---------------------------------------------------------------------------
//  channel     | dir | transfer                       | accepted when
//  ------------+-----+--------------------------------+------------------
//  byte_in     | in  | one descriptor byte, end flag  | valid & ready
//  result_out  | out | endpoint record / end result   | valid & ready
//  cfg         | in  | register index + write data    | valid & ready
//
//  one byte is taken per cycle while byte_in.ready is high; its state update is done in the same cycle
//  a byte gives zero, one or two results, queued in a four-entry result queue
//  byte_in.ready is high while the queue has room for two results, so bytes
//  keep flowing while a result waits, and stop only under output back-pressure
//  first result can be taken in the cycle after the byte transfer
//  rst_n clears walk state, queue and registers (wanted config value to 1)
// ---------------------------------------------------------------------------
`include "usb_config_endpoint_extractor_unit_defines.svh"

module usb_config_endpoint_extractor_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    ucee_cfg_if.sink             cfg,
    ucee_byte_if.sink            byte_in,
    ucee_result_if.source        result_out
);

    // configuration registers
    logic [7:0] wanted_cfg_reg;
    logic [7:0] target_if_reg;
    logic [7:0] target_alt_reg;

    // walk state
    logic [15:0] offset_reg,      offset_next;
    logic [7:0]  desc_idx_reg,    desc_idx_next;
    logic [7:0]  desc_len_reg,    desc_len_next;
    logic [7:0]  desc_type_reg,   desc_type_next;
    logic [7:0]  desc_bytes_reg   [ucee_pkg::DESC_BYTES_DEPTH];
    logic [7:0]  desc_bytes_next  [ucee_pkg::DESC_BYTES_DEPTH];
    logic        in_target_reg,   in_target_next;
    logic        cfg_match_reg,   cfg_match_next;
    logic        stopped_reg,     stopped_next;
    ucee_pkg::record_t pending_reg, pending_next;
    logic        pend_valid_reg,  pend_valid_next;

    // per-byte working values
    logic [7:0]  b;
    logic        eob;
    logic        in_fire;
    logic        cfg_match_s;
    logic [7:0]  desc_idx_s;
    logic [7:0]  desc_len_s;
    logic [7:0]  desc_type_s;
    logic        stopped_s;
    logic        in_target_s;
    ucee_pkg::record_t pending_s;
    logic        pend_valid_s;
    logic        finish;
    logic        emit;
    logic [15:0] offset_s;
    logic [ucee_pkg::DESC_SLOT_W-1:0] slot;
    ucee_pkg::walk_status_t end_status;
    ucee_pkg::result_t emit_res;
    ucee_pkg::result_t end_res;

    // result queue
    ucee_pkg::result_t queue_reg [ucee_pkg::QUEUE_DEPTH];
    logic [ucee_pkg::QPTR_W-1:0] head_reg, head_next;
    logic [ucee_pkg::QCNT_W-1:0] count_reg, count_next;
    logic [ucee_pkg::QPTR_W-1:0] tail;
    logic [ucee_pkg::QPTR_W-1:0] tail_plus;
    logic                        pop;
    logic                        push_emit;
    logic                        push_end;

    assign b       = byte_in.data_byte;
    assign eob     = byte_in.end_of_blob;
    assign in_fire = byte_in.valid & byte_in.ready;

    // room for the worst case of two results from one byte
    assign byte_in.ready = (count_reg <= ucee_pkg::QCNT_W'(ucee_pkg::QUEUE_DEPTH - 2));

    // ---------------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_cfg_reg <= ucee_pkg::WANTED_CONFIG_RESET;
            target_if_reg  <= '0;
            target_alt_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.reg_index)
                ucee_pkg::REG_WANTED_CONFIG: wanted_cfg_reg <= cfg.wdata;
                ucee_pkg::REG_TARGET_IF:     target_if_reg  <= cfg.wdata;
                ucee_pkg::REG_TARGET_ALT:    target_alt_reg <= cfg.wdata;
                default:                     ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // descriptor walk for the incoming byte
    // ---------------------------------------------------------------------
    assign slot = ucee_pkg::DESC_SLOT_W'(desc_idx_reg - 8'd2);

    always_comb
    begin
        // bConfigurationValue sits at offset 5
        cfg_match_s = (offset_reg == ucee_pkg::CONFIG_VALUE_OFFS) ? (b == wanted_cfg_reg)
                                                                  : cfg_match_reg;
        desc_idx_s  = desc_idx_reg;
        desc_len_s  = desc_len_reg;
        desc_type_s = desc_type_reg;
        stopped_s   = stopped_reg;
        finish      = 1'b0;
        for (int i = 0; i < ucee_pkg::DESC_BYTES_DEPTH; i++)
        begin
            desc_bytes_next[i] = desc_bytes_reg[i];
        end

        if (!stopped_reg)
        begin
            if (desc_idx_reg == 8'd0)
            begin
                // bLength byte
                desc_len_s = b;
                if (b < ucee_pkg::MIN_DESC_LEN)
                begin
                    stopped_s = 1'b1;
                end
                else
                begin
                    desc_idx_s = 8'd1;
                end
            end
            else
            begin
                if (desc_idx_reg == 8'd1)
                begin
                    desc_type_s = b;
                end
                else if (desc_idx_reg <= ucee_pkg::LAST_KEPT_INDEX)
                begin
                    desc_bytes_next[slot] = b;
                end
                if ({1'b0, desc_idx_reg} + 9'd1 >= {1'b0, desc_len_reg})
                begin
                    finish     = 1'b1;
                    desc_idx_s = 8'd0;
                end
                else
                begin
                    desc_idx_s = desc_idx_reg + 8'd1;
                end
            end
        end
    end

    // act on a completed descriptor
    always_comb
    begin
        in_target_s  = in_target_reg;
        pending_s    = pending_reg;
        pend_valid_s = pend_valid_reg;
        emit         = 1'b0;

        if (finish)
        begin
            if (desc_type_s == ucee_pkg::DT_INTERFACE && desc_len_s >= ucee_pkg::IF_DESC_LEN)
            begin
                in_target_s = (desc_bytes_next[0] == target_if_reg) &&
                              (desc_bytes_next[1] == target_alt_reg);
            end
            else if (desc_type_s == ucee_pkg::DT_ENDPOINT && in_target_reg &&
                     desc_len_s >= ucee_pkg::EP_DESC_LEN)
            begin
                if (cfg_match_s)
                begin
                    // older pending endpoint goes out, new one takes its place
                    emit                       = pend_valid_reg;
                    pending_s                  = '0;
                    pending_s.endpoint_address = desc_bytes_next[0];
                    pending_s.transfer_type    = desc_bytes_next[1][1:0];
                    pending_s.max_packet_size  = {desc_bytes_next[3], desc_bytes_next[2]};
                    pending_s.poll_interval    = desc_bytes_next[4];
                    pend_valid_s               = 1'b1;
                end
            end
            else if (desc_type_s == ucee_pkg::DT_SS_COMPANION && in_target_reg &&
                     desc_len_s >= ucee_pkg::COMP_DESC_LEN)
            begin
                if (pend_valid_reg)
                begin
                    pending_s.has_companion     = 1'b1;
                    pending_s.burst_max         = desc_bytes_next[0];
                    pending_s.mult_field        = desc_bytes_next[1][1:0];
                    pending_s.bytes_per_service = {desc_bytes_next[3], desc_bytes_next[2]};
                end
            end
        end
    end

    // byte count and end-of-set status
    always_comb
    begin
        offset_s = (offset_reg != ucee_pkg::OFFSET_MAX) ? offset_reg + 16'd1 : offset_reg;

        if (offset_s < ucee_pkg::MIN_CONFIG_BYTES || !cfg_match_s)
        begin
            end_status = ucee_pkg::WALK_REJECTED;
        end
        else if (stopped_s || desc_idx_s != 8'd0)
        begin
            end_status = ucee_pkg::WALK_MALFORMED;
        end
        else
        begin
            end_status = ucee_pkg::WALK_OK;
        end

        emit_res.record_valid = 1'b1;
        emit_res.rec          = pending_reg;
        emit_res.status       = ucee_pkg::WALK_OK;
        emit_res.last_result  = 1'b0;

        end_res.record_valid = (end_status != ucee_pkg::WALK_REJECTED) && pend_valid_s;
        end_res.rec          = end_res.record_valid ? pending_s : '0;
        end_res.status       = end_status;
        end_res.last_result  = 1'b1;
    end

    // next state: a final byte returns the walk to its start
    always_comb
    begin
        offset_next     = offset_reg;
        desc_idx_next   = desc_idx_reg;
        desc_len_next   = desc_len_reg;
        desc_type_next  = desc_type_reg;
        in_target_next  = in_target_reg;
        cfg_match_next  = cfg_match_reg;
        stopped_next    = stopped_reg;
        pending_next    = pending_reg;
        pend_valid_next = pend_valid_reg;

        if (in_fire)
        begin
            if (eob)
            begin
                offset_next     = '0;
                desc_idx_next   = '0;
                desc_len_next   = '0;
                desc_type_next  = '0;
                in_target_next  = 1'b0;
                cfg_match_next  = 1'b0;
                stopped_next    = 1'b0;
                pending_next    = '0;
                pend_valid_next = 1'b0;
            end
            else
            begin
                offset_next     = offset_s;
                desc_idx_next   = desc_idx_s;
                desc_len_next   = desc_len_s;
                desc_type_next  = desc_type_s;
                in_target_next  = in_target_s;
                cfg_match_next  = cfg_match_s;
                stopped_next    = stopped_s;
                pending_next    = pending_s;
                pend_valid_next = pend_valid_s;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg     <= '0;
            desc_idx_reg   <= '0;
            desc_len_reg   <= '0;
            desc_type_reg  <= '0;
            in_target_reg  <= 1'b0;
            cfg_match_reg  <= 1'b0;
            stopped_reg    <= 1'b0;
            pending_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg     <= offset_next;
            desc_idx_reg   <= desc_idx_next;
            desc_len_reg   <= desc_len_next;
            desc_type_reg  <= desc_type_next;
            in_target_reg  <= in_target_next;
            cfg_match_reg  <= cfg_match_next;
            stopped_reg    <= stopped_next;
            pending_reg    <= pending_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // descriptor body bytes need no reset, only written bytes are decoded
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < ucee_pkg::DESC_BYTES_DEPTH; i++)
            begin
                desc_bytes_reg[i] <= desc_bytes_next[i];
            end
        end
    end

    // ---------------------------------------------------------------------
    // result queue: an emitted endpoint goes ahead of the end result
    // ---------------------------------------------------------------------
    assign push_emit = in_fire & emit;
    assign push_end  = in_fire & eob;
    assign pop       = result_out.valid & result_out.ready;
    assign tail      = head_reg + count_reg[ucee_pkg::QPTR_W-1:0];
    assign tail_plus = tail + ucee_pkg::QPTR_W'(1);

    always_comb
    begin
        head_next  = pop ? head_reg + ucee_pkg::QPTR_W'(1) : head_reg;
        count_next = count_reg + ucee_pkg::QCNT_W'(push_emit) + ucee_pkg::QCNT_W'(push_end)
                     - ucee_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_emit)
        begin
            queue_reg[tail] <= emit_res;
            if (push_end)
            begin
                queue_reg[tail_plus] <= end_res;
            end
        end
        else if (push_end)
        begin
            queue_reg[tail] <= end_res;
        end
    end

    assign result_out.valid             = (count_reg != '0);
    assign result_out.record_valid      = queue_reg[head_reg].record_valid;
    assign result_out.endpoint_address  = queue_reg[head_reg].rec.endpoint_address;
    assign result_out.transfer_type     = queue_reg[head_reg].rec.transfer_type;
    assign result_out.max_packet_size   = queue_reg[head_reg].rec.max_packet_size;
    assign result_out.poll_interval     = queue_reg[head_reg].rec.poll_interval;
    assign result_out.has_companion     = queue_reg[head_reg].rec.has_companion;
    assign result_out.burst_max         = queue_reg[head_reg].rec.burst_max;
    assign result_out.mult_field        = queue_reg[head_reg].rec.mult_field;
    assign result_out.bytes_per_service = queue_reg[head_reg].rec.bytes_per_service;
    assign result_out.walk_status       = queue_reg[head_reg].status;
    assign result_out.last_result       = queue_reg[head_reg].last_result;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    `UCEE_ASSERT_NOW(a_queue_bound, 1'b1, count_reg <= ucee_pkg::QCNT_W'(ucee_pkg::QUEUE_DEPTH), "result queue overflow")
    `UCEE_ASSERT_NEXT(a_end_clears, in_fire && eob, offset_reg == '0 && !pend_valid_reg && !stopped_reg, "walk state not cleared after final byte")
    `UCEE_ASSERT_NOW(a_stop_idle, stopped_reg, desc_idx_reg == '0, "descriptor index moved after walk stopped")
    `UCEE_ASSERT_NOW(a_pend_matched, pend_valid_reg, cfg_match_reg, "endpoint pending without configuration match")
    `UCEE_ASSERT_NOW(a_comp_pend, pending_reg.has_companion, pend_valid_reg, "companion merged without pending endpoint")

endmodule
